// File: hdl/tgpe_pkg.sv
// shared types and constants for the touch grid pad edge event block
package tgpe_pkg;

	localparam int TOUCH_W = 12;
	localparam int ROW_MAP_W = 16;
	localparam int COL_MAP_W = 32;
	localparam int ELEC_W = 4;
	localparam int ROW_W = 2;
	localparam int COL_W = 3;
	localparam int PAD_W = 5;
	localparam int LEVEL_W = 32;
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [ROW_MAP_W-1:0] ROW_MAP_RESET = 16'h0123;
	localparam logic [COL_MAP_W-1:0] COL_MAP_RESET = 32'hBA98_7654;

	// register index, taken from paddr[2]
	localparam logic REG_ROW_MAP = 1'b0;
	localparam logic REG_COL_MAP = 1'b1;

	typedef struct packed {
		logic [ROW_MAP_W-1:0] row_map;
		logic [COL_MAP_W-1:0] col_map;
	} maps_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pad_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LATCH,
		ST_EMIT
	} seq_state_t;

endpackage

// File: hdl/tgpe_cfg.sv
// apb register file holding the row and column electrode maps
module tgpe_cfg import tgpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output maps_t             maps
);

	logic [ROW_MAP_W-1:0] row_map_q;
	logic [COL_MAP_W-1:0] col_map_q;
	logic                 wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_map_q <= ROW_MAP_RESET;
			col_map_q <= COL_MAP_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_ROW_MAP: row_map_q <= pwdata[ROW_MAP_W-1:0];
				REG_COL_MAP: col_map_q <= pwdata[COL_MAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ROW_MAP: prdata = {{(APB_DW-ROW_MAP_W){1'b0}}, row_map_q};
			REG_COL_MAP: prdata = col_map_q;
			default:     prdata = '0;
		endcase
	end

	assign maps.row_map = row_map_q;
	assign maps.col_map = col_map_q;

endmodule

// File: hdl/tgpe_pad_unit.sv
// shared pad evaluator: looks up one pad's row and column electrodes and tests both
module tgpe_pad_unit import tgpe_pkg::*; #(
	parameter int ELECTRODE_COUNT = 12
) (
	input  maps_t              maps,
	input  logic [TOUCH_W-1:0] touch,
	input  pad_sel_t           sel,
	output logic               level
);

	localparam int ELEC_N = 1 << ELEC_W;
	localparam logic [ELEC_N-1:0] ELEC_MASK =
		ELEC_N'((33'd1 << ELECTRODE_COUNT) - 33'd1);

	logic [ELEC_N-1:0] touch_ext;
	logic [ELEC_W-1:0] row_elec;
	logic [ELEC_W-1:0] col_elec;

	// electrodes past the count never read touched
	assign touch_ext = {{(ELEC_N-TOUCH_W){1'b0}}, touch} & ELEC_MASK;
	assign row_elec  = maps.row_map[{sel.row, 2'b00} +: ELEC_W];
	assign col_elec  = maps.col_map[{sel.col, 2'b00} +: ELEC_W];
	assign level     = touch_ext[row_elec] & touch_ext[col_elec];

endmodule

// File: hdl/tgpe_seq.sv
// sequencer: scans pads through the shared unit, keeps levels, walks changes into events
module tgpe_seq import tgpe_pkg::*; #(
	parameter int ROW_COUNT    = 4,
	parameter int COLUMN_COUNT = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               touch_valid,
	output logic               touch_ready,
	input  logic [TOUCH_W-1:0] touch_bits,
	output logic               event_valid,
	input  logic               event_ready,
	output logic [PAD_W-1:0]   pad_index,
	output logic               pressed,
	output logic               last_event,
	output logic [LEVEL_W-1:0] pad_levels,
	output logic [TOUCH_W-1:0] touch,
	output pad_sel_t           sel,
	input  logic               level
);

	localparam int PADS = ROW_COUNT * COLUMN_COUNT;
	localparam logic [PAD_W-1:0] LAST_PAD = PAD_W'(PADS - 1);
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMN_COUNT - 1);

	seq_state_t           state_q, state_d;
	logic [TOUCH_W-1:0]   touch_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;
	logic [PAD_W-1:0]     pad_q;
	logic [LEVEL_W-1:0]   next_q;
	logic [LEVEL_W-1:0]   store_q;
	logic [LEVEL_W-1:0]   changed_q;
	logic                 out_valid_q;
	logic [PAD_W-1:0]     out_pad_q;
	logic                 out_pressed_q;
	logic                 out_last_q;
	logic [LEVEL_W-1:0]   out_levels_q;

	logic                 in_xfer;
	logic                 out_free;
	logic                 pad_changed;
	logic                 none_above;
	logic                 emit_load;
	logic                 emit_step;
	logic                 at_last_pad;

	assign in_xfer     = touch_valid & touch_ready;
	assign out_free    = ~out_valid_q | event_ready;
	assign pad_changed = changed_q[pad_q];
	assign none_above  = ((changed_q >> pad_q) >> 1) == '0;
	assign at_last_pad = (pad_q == LAST_PAD);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (touch_valid) state_d = ST_SCAN;
			ST_SCAN:  if (at_last_pad) state_d = ST_LATCH;
			ST_LATCH: state_d = ST_EMIT;
			ST_EMIT:  if (emit_step && at_last_pad) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		touch_ready = 1'b0;
		emit_load   = 1'b0;
		emit_step   = 1'b0;
		case (state_q)
			ST_IDLE: touch_ready = 1'b1;
			ST_EMIT: begin
				emit_load = pad_changed & out_free;
				emit_step = ~pad_changed | out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			row_q     <= '0;
			col_q     <= '0;
			pad_q     <= '0;
			store_q   <= '0;
			changed_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					col_q <= '0;
					pad_q <= '0;
				end
				ST_SCAN: begin
					pad_q <= pad_q + 1'b1;
					if (col_q == LAST_COL) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_LATCH: begin
					changed_q <= next_q ^ store_q;
					store_q   <= next_q;
					pad_q     <= '0;
				end
				ST_EMIT: if (emit_step) pad_q <= pad_q + 1'b1;
				default: ;
			endcase
		end
	end

	// payload: touch word and the levels gathered during the scan
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			touch_q <= touch_bits;
			next_q  <= '0;
		end else if (state_q == ST_SCAN) begin
			next_q[pad_q] <= level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (event_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_pad_q     <= pad_q;
			out_pressed_q <= store_q[pad_q];
			out_last_q    <= none_above;
			out_levels_q  <= store_q;
		end
	end

	assign touch       = touch_q;
	assign sel.row     = row_q;
	assign sel.col     = col_q;
	assign event_valid = out_valid_q;
	assign pad_index   = out_pad_q;
	assign pressed     = out_pressed_q;
	assign last_event  = out_last_q;
	assign pad_levels  = out_levels_q;

endmodule

// File: hdl/touch_grid_pad_edge_events.sv
// top level of the touch grid pad edge event block
//
//  channel   direction  handshake                    payload
//  touch     in         touch_valid / touch_ready    touch_bits
//  event     out        event_valid / event_ready    pad_index, pressed, last_event, pad_levels
//  config    in         apb psel/penable/pready      paddr, pwdata, prdata
//
// one touch word takes a scan of every pad, one pad per cycle through the shared pad
// unit, then a latch of the diff, then a walk over every pad, one pad per cycle while no
// event waits on event_ready.
// touch_ready is high only while the sequencer is idle; the last event of a word can
// still sit in the output register while the next word is taken.
// arst_n clears the pad levels to all released and the maps to their default values.
module touch_grid_pad_edge_events import tgpe_pkg::*; #(
	parameter int ROW_COUNT       = 4,
	parameter int COLUMN_COUNT    = 8,
	parameter int ELECTRODE_COUNT = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               touch_valid,
	output logic               touch_ready,
	input  logic [TOUCH_W-1:0] touch_bits,
	output logic               event_valid,
	input  logic               event_ready,
	output logic [PAD_W-1:0]   pad_index,
	output logic               pressed,
	output logic               last_event,
	output logic [LEVEL_W-1:0] pad_levels,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               pready
);

	maps_t              maps;
	pad_sel_t           sel;
	logic [TOUCH_W-1:0] touch;
	logic               level;

	tgpe_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.maps    (maps)
	);

	tgpe_pad_unit #(
		.ELECTRODE_COUNT (ELECTRODE_COUNT)
	) u_pad_unit (
		.maps  (maps),
		.touch (touch),
		.sel   (sel),
		.level (level)
	);

	tgpe_seq #(
		.ROW_COUNT    (ROW_COUNT),
		.COLUMN_COUNT (COLUMN_COUNT)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.touch_valid (touch_valid),
		.touch_ready (touch_ready),
		.touch_bits  (touch_bits),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.pad_index   (pad_index),
		.pressed     (pressed),
		.last_event  (last_event),
		.pad_levels  (pad_levels),
		.touch       (touch),
		.sel         (sel),
		.level       (level)
	);

endmodule

// File: hdl/tgpe_checker.sv
// port-level checks for the touch grid pad edge event block
module tgpe_checker import tgpe_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               touch_valid,
	input logic               touch_ready,
	input logic               event_valid,
	input logic               event_ready,
	input logic [PAD_W-1:0]   pad_index,
	input logic               pressed,
	input logic               last_event,
	input logic [LEVEL_W-1:0] pad_levels
);

	// a stalled event holds its payload
	a_event_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && !event_ready) |=>
		(event_valid && $stable(pad_index) && $stable(pressed) &&
		 $stable(last_event) && $stable(pad_levels)))
		else $error("event payload changed while stalled");

	// a word keeps the sequencer busy, so the input closes right after a transfer
	a_busy_after_touch: assert property (@(posedge clk) disable iff (!arst_n)
		(touch_valid && touch_ready) |=> !touch_ready)
		else $error("touch accepted back to back");

	// the reported edge direction matches the new level of that pad
	a_level_match: assert property (@(posedge clk) disable iff (!arst_n)
		event_valid |-> (pad_levels[pad_index] == pressed))
		else $error("pressed flag disagrees with pad_levels");

	// while more events of a word are pending, no new word can be taken
	a_run_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && !last_event) |-> !touch_ready)
		else $error("touch ready in the middle of an event run");

endmodule

bind touch_grid_pad_edge_events tgpe_checker u_tgpe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.touch_valid (touch_valid),
	.touch_ready (touch_ready),
	.event_valid (event_valid),
	.event_ready (event_ready),
	.pad_index   (pad_index),
	.pressed     (pressed),
	.last_event  (last_event),
	.pad_levels  (pad_levels)
);

// File: bench/touch_grid_pad_edge_events_tb.sv
// testbench for the touch grid pad edge event block: scoreboard against a local grid predictor
`timescale 1ns / 100ps

module touch_grid_pad_edge_events_tb;
	import tgpe_pkg::*;

	localparam int ROWS = 4;
	localparam int COLS = 8;
	localparam int ELECTRODES = 12;
	localparam int PADS = ROWS * COLS;
	// scan plus walk of one word, with some margin
	localparam int WORD_LATENCY = 2 * PADS + 12;
	localparam int HOLD_CYCLES = 400;
	localparam int CYCLE_LIMIT = 400000;
	localparam int WORDS_PER_MIX = 35;

	typedef struct packed {
		logic [PAD_W-1:0]   idx;
		logic               pressed;
		logic               last;
		logic [LEVEL_W-1:0] levels;
	} pad_event_t;

	logic               clk;
	logic               arst_n;
	logic               touch_valid;
	logic               touch_ready;
	logic [TOUCH_W-1:0] touch_bits;
	logic               event_valid;
	logic               event_ready;
	logic [PAD_W-1:0]   pad_index;
	logic               pressed;
	logic               last_event;
	logic [LEVEL_W-1:0] pad_levels;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	// mirror of the block's registers and pad levels
	logic [ROW_MAP_W-1:0] row_map_mirror;
	logic [COL_MAP_W-1:0] col_map_mirror;
	logic [LEVEL_W-1:0]   level_mirror;
	pad_event_t           pending_pad_events [$];

	int err_count = 0;
	int words_accepted = 0;
	int events_checked = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct;
	int hold_token;
	int hold_token_seen = 0;
	int hold_left = 0;
	int idle_mix [4] = '{0, 62, 0, 25};
	int stall_mix [4] = '{0, 0, 62, 25};

	touch_grid_pad_edge_events dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.touch_valid (touch_valid),
		.touch_ready (touch_ready),
		.touch_bits  (touch_bits),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.pad_index   (pad_index),
		.pressed     (pressed),
		.last_event  (last_event),
		.pad_levels  (pad_levels),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d events still pending", cycle_count,
				pending_pad_events.size());
			$display("Verification failed");
			$finish;
		end
	end

	// electrodes past the sensor count never read touched
	function automatic logic electrode_hit(input logic [TOUCH_W-1:0] word,
		input logic [ELEC_W-1:0] elec);
		if (elec >= ELECTRODES)
			return 1'b0;
		return word[elec];
	endfunction

	function automatic logic [LEVEL_W-1:0] scan_pad_levels(input logic [TOUCH_W-1:0] word);
		logic [LEVEL_W-1:0] lv;
		lv = '0;
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLS; c++)
				if (electrode_hit(word, row_map_mirror[4*r +: 4]) &&
					electrode_hit(word, col_map_mirror[4*c +: 4]))
					lv[r*COLS + c] = 1'b1;
		return lv;
	endfunction

	task automatic apply_touch_word(input logic [TOUCH_W-1:0] word);
		logic [LEVEL_W-1:0] next_lv;
		logic [LEVEL_W-1:0] diff;
		pad_event_t ev;
		int last_idx;
		next_lv = scan_pad_levels(word);
		diff = next_lv ^ level_mirror;
		last_idx = -1;
		for (int i = 0; i < PADS; i++)
			if (diff[i])
				last_idx = i;
		for (int i = 0; i < PADS; i++) begin
			if (diff[i]) begin
				ev.idx = i[PAD_W-1:0];
				ev.pressed = next_lv[i];
				ev.last = (i == last_idx);
				ev.levels = next_lv;
				pending_pad_events.push_back(ev);
			end
		end
		level_mirror = next_lv;
		words_accepted++;
	endtask

	always @(posedge clk) begin : event_check
		pad_event_t want;
		if (arst_n && event_valid && event_ready) begin
			if (pending_pad_events.size() == 0) begin
				$display("%0t unexpected event: idx %0d pressed %0b last %0b levels %h", $time,
					pad_index, pressed, last_event, pad_levels);
				err_count++;
			end else begin
				want = pending_pad_events.pop_front();
				events_checked++;
				if (want.idx !== pad_index || want.pressed !== pressed ||
					want.last !== last_event || want.levels !== pad_levels) begin
					$display({"%0t event mismatch: expected idx %0d pressed %0b last %0b",
						" levels %h, got idx %0d pressed %0b last %0b levels %h"},
						$time, want.idx, want.pressed, want.last, want.levels,
						pad_index, pressed, last_event, pad_levels);
					err_count++;
				end
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_token != hold_token_seen) begin
			hold_token_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			event_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			event_ready <= 1'b0;
		end else begin
			event_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic offer_touch_word(input logic [TOUCH_W-1:0] word);
		touch_valid <= 1'b1;
		touch_bits <= word;
		do @(posedge clk); while (!(touch_valid && touch_ready));
		apply_touch_word(word);
		if ($urandom_range(99) < idle_pct) begin
			touch_valid <= 1'b0;
			repeat ($urandom_range(1, 90)) @(posedge clk);
		end
	endtask

	// wait for every event, then let a word with no change finish its scan
	task automatic settle_idle();
		touch_valid <= 1'b0;
		while (pending_pad_events.size() != 0)
			@(posedge clk);
		repeat (WORD_LATENCY) @(posedge clk);
	endtask

	// write one map register, read it back, then leave the bus idle
	task automatic write_map_reg(input logic reg_sel, input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] read_want;
		if (reg_sel == REG_ROW_MAP)
			read_want = APB_DW'(value[ROW_MAP_W-1:0]);
		else
			read_want = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== read_want) begin
			$display("%0t register readback mismatch: expected %h, got %h", $time,
				read_want, prdata);
			err_count++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (reg_sel == REG_ROW_MAP)
			row_map_mirror = value[ROW_MAP_W-1:0];
		else
			col_map_mirror = value[COL_MAP_W-1:0];
	endtask

	// mostly in-range electrode numbers, some past the sensor count
	function automatic logic [APB_DW-1:0] random_map_value(input int nibbles);
		logic [APB_DW-1:0] v;
		v = '0;
		for (int n = 0; n < nibbles; n++)
			v[4*n +: 4] = ($urandom_range(9) < 8) ? 4'($urandom_range(0, ELECTRODES - 1))
				: 4'($urandom_range(ELECTRODES, 15));
		return v;
	endfunction

	function automatic logic [TOUCH_W-1:0] random_touch_word(input logic [TOUCH_W-1:0] prev_word);
		logic [TOUCH_W-1:0] w;
		logic [ELEC_W-1:0] elec;
		int pick;
		pick = $urandom_range(9);
		w = '0;
		case (pick)
			0: w = '0;
			1, 2, 3: begin
				w = prev_word;
				w[$urandom_range(TOUCH_W - 1)] ^= 1'b1;
				if ($urandom_range(1))
					w[$urandom_range(TOUCH_W - 1)] ^= 1'b1;
			end
			4, 5, 6: begin
				// one or two real row/column presses
				repeat ((pick == 6) ? 2 : 1) begin
					elec = row_map_mirror[4*$urandom_range(ROWS - 1) +: 4];
					if (elec < ELECTRODES)
						w[elec] = 1'b1;
					elec = col_map_mirror[4*$urandom_range(COLS - 1) +: 4];
					if (elec < ELECTRODES)
						w[elec] = 1'b1;
				end
			end
			default: w = TOUCH_W'($urandom_range(0, (1 << TOUCH_W) - 1));
		endcase
		return w;
	endfunction

	task automatic test_default_maps();
		idle_pct = 0;
		offer_touch_word(12'h000);
		offer_touch_word(12'hFFF);
		offer_touch_word(12'hFFF);
		offer_touch_word(12'h018);
		offer_touch_word(12'h818);
		offer_touch_word(12'h801);
		offer_touch_word(12'h00F);
		offer_touch_word(12'hFF0);
		offer_touch_word(12'h000);
		settle_idle();
	endtask

	task automatic test_map_extremes();
		// every row and column on electrode 0
		write_map_reg(REG_ROW_MAP, 32'h0000_0000);
		write_map_reg(REG_COL_MAP, 32'h0000_0000);
		offer_touch_word(12'h001);
		offer_touch_word(12'hFFE);
		settle_idle();
		// all electrodes out of range
		write_map_reg(REG_ROW_MAP, 32'h0000_FFFF);
		write_map_reg(REG_COL_MAP, 32'hFFFF_FFFF);
		offer_touch_word(12'hFFF);
		settle_idle();
		write_map_reg(REG_ROW_MAP, 32'h0000_F0C1);
		write_map_reg(REG_COL_MAP, 32'h7654_3210);
		offer_touch_word(12'h0FF);
		offer_touch_word(12'h003);
		offer_touch_word(12'hFFF);
		offer_touch_word(12'h000);
		settle_idle();
		write_map_reg(REG_ROW_MAP, {16'h0, ROW_MAP_RESET});
		write_map_reg(REG_COL_MAP, COL_MAP_RESET);
		offer_touch_word(12'h828);
		settle_idle();
	endtask

	task automatic test_random_words();
		logic [TOUCH_W-1:0] word;
		word = '0;
		for (int mix = 0; mix < 4; mix++) begin
			settle_idle();
			write_map_reg(REG_ROW_MAP, random_map_value(ROW_MAP_W / 4));
			write_map_reg(REG_COL_MAP, random_map_value(COL_MAP_W / 4));
			idle_pct = idle_mix[mix];
			stall_pct <= stall_mix[mix];
			repeat (WORDS_PER_MIX) begin
				word = random_touch_word(word);
				offer_touch_word(word);
			end
		end
		settle_idle();
	endtask

	task automatic test_receiver_hold_off();
		write_map_reg(REG_ROW_MAP, {16'h0, ROW_MAP_RESET});
		write_map_reg(REG_COL_MAP, COL_MAP_RESET);
		idle_pct = 0;
		stall_pct <= 0;
		hold_token <= hold_token + 1;
		// full swings keep the output stuck while more words wait at the input
		repeat (3) begin
			offer_touch_word(12'hFFF);
			offer_touch_word(12'h000);
		end
		settle_idle();
	endtask

	initial begin
		arst_n <= 1'b0;
		touch_valid <= 1'b0;
		touch_bits <= '0;
		event_ready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		stall_pct <= 0;
		hold_token <= 0;
		row_map_mirror = ROW_MAP_RESET;
		col_map_mirror = COL_MAP_RESET;
		level_mirror = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_maps();
		test_map_extremes();
		test_random_words();
		test_receiver_hold_off();
		settle_idle();

		$display("ran %0d touch words and checked %0d pad events under four idle/stall mixes,",
			words_accepted, events_checked);
		$display("with map extremes, out-of-range electrodes and a %0d-cycle receiver hold-off",
			HOLD_CYCLES);
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
